/* hdl/ted_pkg.sv */
// Package for the typed event deque: sizes, request codes, item and control types.
`default_nettype none
package ted_pkg;

   localparam int QUEUE_DEPTH = 16;
   localparam int HANDLE_BITS = 16;

   localparam int HND_W = (HANDLE_BITS < 16) ? HANDLE_BITS : 16;
   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [7:0] ABORT_MASK = 8'h80;

   typedef enum logic [2:0] {
      RQ_REPLACE     = 3'd0,
      RQ_PUSH_BACK   = 3'd1,
      RQ_PUSH_FRONT  = 3'd2,
      RQ_POP         = 3'd3,
      RQ_POP_EQUAL   = 3'd4,
      RQ_POP_NEITHER = 3'd5,
      RQ_FLUSH       = 3'd6
   } req_code_type;

   typedef enum logic [2:0] {
      CM_HOLD,
      CM_PULL_NEXT,
      CM_PULL_PREV,
      CM_WR_TAIL,
      CM_WR_HEAD
   } cell_mode_type;

   typedef struct packed {
      cell_mode_type     mode;
      logic [IDX_W-1:0]  tail_idx;
   } cell_ctl_type;

   typedef struct packed {
      logic [HND_W-1:0] handle;
      logic [7:0]       kind;
   } entry_type;

   typedef struct packed {
      logic [2:0]  req_type;
      logic [15:0] event_handle;
      logic [7:0]  event_kind;
      logic [7:0]  match_type_a;
      logic [7:0]  match_type_b;
   } req_item_type;

   typedef struct packed {
      logic        popped_valid;
      logic [15:0] popped_handle;
      logic [7:0]  popped_kind;
      logic        head_valid;
      logic [7:0]  head_kind;
      logic        head_is_abort;
      logic        head_differs;
      logic [4:0]  discarded_count;
      logic        push_rejected;
      logic [4:0]  entry_count;
   } rsp_item_type;

   function automatic logic [4:0] count_to_field(input logic [CNT_W-1:0] c);
      logic [31:0] w;
      w = 32'(c);
      return w[4:0];
   endfunction

endpackage
`default_nettype wire

/* hdl/ted_cell.sv */
// One deque slot: holds an entry and takes its neighbor's, the new one, or keeps its own.
`default_nettype none
module ted_cell import ted_pkg::*; (
   input  wire logic              clock,
   input  wire logic [IDX_W-1:0]  idx,
   input  wire cell_ctl_type      ctl,
   input  wire entry_type         prev_d,
   input  wire entry_type         next_d,
   input  wire entry_type         new_d,
   output      entry_type         entry_q
);

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      case (ctl.mode)
         CM_HOLD:      entry_in = entry_ff;
         CM_PULL_NEXT: entry_in = next_d;
         CM_PULL_PREV: entry_in = prev_d;
         CM_WR_TAIL:   if (idx == ctl.tail_idx) entry_in = new_d;
         CM_WR_HEAD:   if (idx == '0) entry_in = new_d;
         default:      entry_in = entry_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_q = entry_ff;

endmodule
`default_nettype wire

/* hdl/typed_event_deque_core.sv */
// Typed event deque: a row of shifting slots with the head in slot zero.
// The result item is registered from the request as the request is accepted.
// Throughput: one request per cycle while the result is not stalled; each request moves the whole slot row in one step.
// Reset clears the entry count and the result valid; slot contents stay undefined until written.
`default_nettype none
module typed_event_deque_core import ted_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output      logic          req_stall,
   input  wire req_item_type  req_item,
   output      logic          rsp_valid,
   input  wire logic          rsp_stall,
   output      rsp_item_type  rsp_item
);

   logic [CNT_W-1:0] count_ff;
   logic [CNT_W-1:0] count_in;
   logic             rsp_valid_ff;
   logic             rsp_valid_in;
   rsp_item_type     rsp_item_ff;
   rsp_item_type     rsp_item_in;

   entry_type        cell_q [QUEUE_DEPTH];
   entry_type        new_entry;
   cell_ctl_type     ctl;
   logic             accept;

   logic             empty;
   logic             full;
   logic             do_pop;
   logic             rejected;
   logic [CNT_W-1:0] discarded;
   cell_mode_type    mode;
   entry_type        head_next;

   assign new_entry.handle = req_item.event_handle[HND_W-1:0];
   assign new_entry.kind   = req_item.event_kind;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CNT_W'(QUEUE_DEPTH));

   always_comb begin
      mode      = CM_HOLD;
      count_in  = count_ff;
      do_pop    = 1'b0;
      rejected  = 1'b0;
      discarded = '0;
      head_next = cell_q[0];
      case (req_item.req_type)
         RQ_REPLACE: begin
            discarded = count_ff;
            mode      = CM_WR_HEAD;
            count_in  = CNT_W'(1);
            head_next = new_entry;
         end
         RQ_PUSH_BACK: begin
            if (full) begin
               rejected = 1'b1;
            end else begin
               mode     = CM_WR_TAIL;
               count_in = count_ff + CNT_W'(1);
               if (empty) head_next = new_entry;
            end
         end
         RQ_PUSH_FRONT: begin
            if (full) begin
               rejected = 1'b1;
            end else begin
               mode      = CM_PULL_PREV;
               count_in  = count_ff + CNT_W'(1);
               head_next = new_entry;
            end
         end
         RQ_POP:         do_pop = ~empty;
         RQ_POP_EQUAL:   do_pop = ~empty && (cell_q[0].kind == req_item.match_type_a);
         RQ_POP_NEITHER: do_pop = ~empty && (cell_q[0].kind != req_item.match_type_a)
                                         && (cell_q[0].kind != req_item.match_type_b);
         RQ_FLUSH: begin
            discarded = count_ff;
            count_in  = '0;
         end
         default: ;
      endcase
      if (do_pop) begin
         mode      = CM_PULL_NEXT;
         count_in  = count_ff - CNT_W'(1);
         head_next = cell_q[1];
      end
      if (!accept) begin
         mode     = CM_HOLD;
         count_in = count_ff;
      end
   end

   assign ctl.mode     = mode;
   assign ctl.tail_idx = count_ff[IDX_W-1:0];

   always_comb begin
      rsp_item_in.popped_valid    = do_pop;
      rsp_item_in.popped_handle   = do_pop ? 16'(cell_q[0].handle) : 16'd0;
      rsp_item_in.popped_kind     = do_pop ? cell_q[0].kind : 8'd0;
      rsp_item_in.head_valid      = (count_in != '0);
      rsp_item_in.head_kind       = (count_in != '0) ? head_next.kind : 8'd0;
      rsp_item_in.head_is_abort   = (count_in != '0) && ((head_next.kind & ABORT_MASK) != 8'd0);
      rsp_item_in.head_differs    = ~empty && (cell_q[0].kind != req_item.match_type_a);
      rsp_item_in.discarded_count = count_to_field(discarded);
      rsp_item_in.push_rejected   = rejected;
      rsp_item_in.entry_count     = count_to_field(count_in);
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

   for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
      entry_type prev_d;
      entry_type next_d;
      if (i == 0) begin : g_first
         assign prev_d = new_entry;
      end else begin : g_mid_prev
         assign prev_d = cell_q[i-1];
      end
      if (i == QUEUE_DEPTH - 1) begin : g_last
         assign next_d = cell_q[i];
      end else begin : g_mid_next
         assign next_d = cell_q[i+1];
      end
      ted_cell u_cell (
         .clock   (clock),
         .idx     (IDX_W'(i)),
         .ctl     (ctl),
         .prev_d  (prev_d),
         .next_d  (next_d),
         .new_d   (new_entry),
         .entry_q (cell_q[i])
      );
   end

endmodule
`default_nettype wire

/* test/testbench.sv */
`timescale 1ns / 100ps
// Testbench for typed_event_deque_core: directed and random requests checked by a deque predictor.
module testbench;
   import ted_pkg::*;

   localparam logic [2:0] RQ_UNUSED = 3'd7;
   localparam int EVENT_COUNT = 1850;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_item_type req_item = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_item_type rsp_item;

   req_item_type     pending_reqs[$];
   rsp_item_type     expected_rsps[$];
   entry_type        slots[QUEUE_DEPTH];
   logic [IDX_W-1:0] head_at = '0;
   logic [CNT_W-1:0] held = '0;
   int errors = 0;
   int send_gap = 0;
   int send_burst = 0;
   int stall_left = 0;
   int stall_burst = 0;

   typed_event_deque_core uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #5 clock = ~clock;

   // mostly short gaps, a few long ones, and occasional runs with none
   function automatic int idle_len(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 3) begin
         burst = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic void store_event(input logic [IDX_W-1:0] at, input req_item_type rq);
      slots[at].handle = rq.event_handle[HND_W-1:0];
      slots[at].kind = rq.event_kind;
   endfunction

   function automatic rsp_item_type predict_deque_rsp(input req_item_type rq);
      rsp_item_type r;
      logic [7:0]   front_kind;
      logic         take;
      r = '0;
      take = 1'b0;
      front_kind = (held != 0) ? slots[head_at].kind : 8'h00;
      r.head_differs = (held != 0) && (front_kind != rq.match_type_a);
      case (rq.req_type)
         RQ_REPLACE: begin
            r.discarded_count = 5'(held);
            store_event(head_at, rq);
            held = CNT_W'(1);
         end
         RQ_PUSH_BACK: begin
            if (held == QUEUE_DEPTH) begin
               r.push_rejected = 1'b1;
            end else begin
               store_event(IDX_W'(head_at + held), rq);
               held++;
            end
         end
         RQ_PUSH_FRONT: begin
            if (held == QUEUE_DEPTH) begin
               r.push_rejected = 1'b1;
            end else begin
               head_at = head_at - IDX_W'(1);
               store_event(head_at, rq);
               held++;
            end
         end
         RQ_POP: take = (held != 0);
         RQ_POP_EQUAL: take = (held != 0) && (front_kind == rq.match_type_a);
         RQ_POP_NEITHER: begin
            take = (held != 0) && (front_kind != rq.match_type_a)
                   && (front_kind != rq.match_type_b);
         end
         RQ_FLUSH: begin
            r.discarded_count = 5'(held);
            held = '0;
         end
         default: ;
      endcase
      if (take) begin
         r.popped_valid = 1'b1;
         r.popped_handle = 16'(slots[head_at].handle);
         r.popped_kind = slots[head_at].kind;
         head_at = head_at + IDX_W'(1);
         held--;
      end
      if (held != 0) begin
         r.head_valid = 1'b1;
         r.head_kind = slots[head_at].kind;
         r.head_is_abort = (slots[head_at].kind & ABORT_MASK) != 0;
      end
      r.entry_count = 5'(held);
      return r;
   endfunction

   task automatic cmp_field(input string name, input logic [31:0] exp, input logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected %0h, got %0h", name, exp, act);
         errors++;
      end
   endtask

   task automatic check_rsp(input rsp_item_type exp, input rsp_item_type act);
      cmp_field("popped_valid", 32'(exp.popped_valid), 32'(act.popped_valid));
      cmp_field("popped_handle", 32'(exp.popped_handle), 32'(act.popped_handle));
      cmp_field("popped_kind", 32'(exp.popped_kind), 32'(act.popped_kind));
      cmp_field("head_valid", 32'(exp.head_valid), 32'(act.head_valid));
      cmp_field("head_kind", 32'(exp.head_kind), 32'(act.head_kind));
      cmp_field("head_is_abort", 32'(exp.head_is_abort), 32'(act.head_is_abort));
      cmp_field("head_differs", 32'(exp.head_differs), 32'(act.head_differs));
      cmp_field("discarded_count", 32'(exp.discarded_count), 32'(act.discarded_count));
      cmp_field("push_rejected", 32'(exp.push_rejected), 32'(act.push_rejected));
      cmp_field("entry_count", 32'(exp.entry_count), 32'(act.entry_count));
   endtask

   task automatic queue_req(input logic [2:0] code, input logic [15:0] handle,
                            input logic [7:0] kind, input logic [7:0] ma, input logic [7:0] mb);
      req_item_type rq;
      rq.req_type = code;
      rq.event_handle = handle;
      rq.event_kind = kind;
      rq.match_type_a = ma;
      rq.match_type_b = mb;
      pending_reqs.push_back(rq);
   endtask

   // small pool of kinds so that conditional pops hit often
   function automatic logic [7:0] pick_kind();
      case ($urandom_range(0, 5))
         0: return 8'h01;
         1: return 8'h02;
         2: return 8'h80;
         3: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [15:0] pick_handle();
      case ($urandom_range(0, 9))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   // phase 0 fills, phase 1 drains, phase 2 mixes, phase 3 is noise
   function automatic logic [2:0] pick_code(input int phase);
      int r;
      r = $urandom_range(0, 99);
      case (phase)
         0: begin
            if (r < 45) return RQ_PUSH_BACK;
            if (r < 85) return RQ_PUSH_FRONT;
            if (r < 90) return RQ_POP;
            if (r < 94) return RQ_POP_EQUAL;
            if (r < 97) return RQ_REPLACE;
            if (r < 99) return RQ_FLUSH;
            return RQ_UNUSED;
         end
         1: begin
            if (r < 30) return RQ_POP;
            if (r < 55) return RQ_POP_EQUAL;
            if (r < 80) return RQ_POP_NEITHER;
            if (r < 90) return RQ_PUSH_BACK;
            if (r < 95) return RQ_PUSH_FRONT;
            if (r < 98) return RQ_FLUSH;
            return RQ_UNUSED;
         end
         default: return 3'($urandom_range(0, 7));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(predict_deque_rsp(req_item));
         if (!req_valid || !req_stall) begin
            if (send_gap > 0 || pending_reqs.size() == 0) begin
               req_valid <= 1'b0;
               if (send_gap > 0) send_gap--;
            end else begin
               req_item <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap = idle_len(send_burst);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               $error("result item with none expected: %p", rsp_item);
               errors++;
            end else begin
               check_rsp(expected_rsps.pop_front(), rsp_item);
            end
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = idle_len(stall_burst);
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin
      int issued;
      int phase;
      int r;
      int waited;
      logic [2:0] code;

      // empty queue cases
      queue_req(RQ_POP, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_req(RQ_POP_EQUAL, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_req(RQ_POP_NEITHER, 16'h0000, 8'h00, 8'h01, 8'h02);
      queue_req(RQ_FLUSH, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_req(RQ_UNUSED, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      // both ends, abort kinds, conditional pops hit and miss
      queue_req(RQ_REPLACE, 16'hFFFF, 8'hFF, 8'hFF, 8'h00);
      queue_req(RQ_PUSH_BACK, 16'h0000, 8'h00, 8'h00, 8'hFF);
      queue_req(RQ_PUSH_FRONT, 16'h8000, 8'h80, 8'h7F, 8'h00);
      queue_req(RQ_UNUSED, 16'hFFFF, 8'hFF, 8'h80, 8'hFF);
      queue_req(RQ_POP_EQUAL, 16'h0000, 8'h00, 8'h80, 8'h00);
      queue_req(RQ_POP_EQUAL, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_req(RQ_POP_NEITHER, 16'h0000, 8'h00, 8'hFF, 8'h01);
      queue_req(RQ_POP_NEITHER, 16'h0000, 8'h00, 8'h01, 8'hFF);
      queue_req(RQ_POP_NEITHER, 16'h0000, 8'h00, 8'h01, 8'h02);
      queue_req(RQ_POP, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
      queue_req(RQ_REPLACE, 16'h1234, 8'h7F, 8'h7F, 8'h00);
      queue_req(RQ_REPLACE, 16'hABCD, 8'h81, 8'h00, 8'h00);
      queue_req(RQ_PUSH_BACK, 16'h5555, 8'hAA, 8'h81, 8'h00);
      queue_req(RQ_FLUSH, 16'h0000, 8'h00, 8'h00, 8'h00);
      queue_req(RQ_PUSH_FRONT, 16'hFFFF, 8'hFF, 8'h00, 8'h00);
      queue_req(RQ_POP, 16'h0000, 8'h00, 8'hFF, 8'h00);

      issued = 0;
      while (issued < EVENT_COUNT) begin
         r = $urandom_range(0, 99);
         phase = (r < 35) ? 0 : (r < 70) ? 1 : (r < 90) ? 2 : 3;
         repeat ($urandom_range(8, 40)) begin
            code = pick_code(phase);
            if (phase == 3)
               queue_req(code, 16'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
            else
               queue_req(code, pick_handle(), pick_kind(), pick_kind(), pick_kind());
            if (code != RQ_UNUSED) issued++;
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (pending_reqs.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (expected_rsps.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (4) @(posedge clock);
      if (expected_rsps.size() != 0) begin
         $error("%0d result items never arrived", expected_rsps.size());
         errors++;
      end
      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* sim.f */
hdl/ted_pkg.sv
hdl/ted_cell.sv
hdl/typed_event_deque_core.sv
test/testbench.sv
